### rtl/core/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg: shared types and constants for overlap rectangle suppression
// Word layouts, stored entry layout and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ors_pkg;

  localparam int ORS_COORD_BITS = 12;
  localparam int ORS_AREA_BITS  = 2 * ORS_COORD_BITS;
  localparam int ORS_THR_BITS   = 9;
  localparam int ORS_KEPT_BITS  = 6;
  localparam logic [ORS_THR_BITS-1:0] ORS_THR_RESET = 9'd128;

  typedef logic [ORS_COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    rect_t                    rect;
    logic [ORS_AREA_BITS-1:0] area;
  } entry_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
    logic   batch_end;
  } in_word_t;

  typedef struct packed {
    coord_t                   out_left;
    coord_t                   out_top;
    coord_t                   out_width;
    coord_t                   out_height;
    logic [ORS_KEPT_BITS-1:0] kept_total;
    logic                     overflowed;
    logic                     final_result;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_INS_RD,
    S_INS_CMP,
    S_SUP_RDI,
    S_SUP_LDI,
    S_SUP_RDJ,
    S_SUP_D0,
    S_SUP_D1,
    S_SUP_CMP,
    S_EM_RD,
    S_EM_CK
  } ors_state_t;

endpackage

`default_nettype wire

### rtl/core/ors_rect_mem.sv
// ----------------------------------------------------------------------------
// ors_rect_mem: rectangle store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_rect_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire              clk,
  input  wire              wr_en,
  input  wire [AW-1:0]     wr_addr,
  input  ors_pkg::entry_t  wr_data,
  input  wire              rd_en,
  input  wire [AW-1:0]     rd_addr,
  output ors_pkg::entry_t  rd_data
);
  import ors_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ors_overlap.sv
// ----------------------------------------------------------------------------
// ors_overlap: intersection area of two rectangles
// Two register stages: clipped extents, then their product.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_overlap (
  input  wire                                    clk,
  input  ors_pkg::rect_t                         rect_a,
  input  ors_pkg::rect_t                         rect_b,
  output logic [2*ors_pkg::ORS_COORD_BITS+1:0]   inter_area
);
  import ors_pkg::*;

  localparam int EW = ORS_COORD_BITS + 1;

  logic [EW-1:0] x1, y1, x2, y2, ax2, bx2, ay2, by2;
  logic [EW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;

  always_comb begin
    x1  = (rect_a.l > rect_b.l) ? {1'b0, rect_a.l} : {1'b0, rect_b.l};
    y1  = (rect_a.t > rect_b.t) ? {1'b0, rect_a.t} : {1'b0, rect_b.t};
    ax2 = {1'b0, rect_a.l} + {1'b0, rect_a.w};
    bx2 = {1'b0, rect_b.l} + {1'b0, rect_b.w};
    ay2 = {1'b0, rect_a.t} + {1'b0, rect_a.h};
    by2 = {1'b0, rect_b.t} + {1'b0, rect_b.h};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    // empty in either axis gives zero area
    if (x2 <= x1 || y2 <= y1) begin
      dx_nxt = '0;
      dy_nxt = '0;
    end else begin
      dx_nxt = x2 - x1;
      dy_nxt = y2 - y1;
    end
  end

  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    inter_area <= dx_r * dy_r;
  end

endmodule

`default_nettype wire

### rtl/core/overlap_rect_suppression.sv
// Insertion: a stored word holds in_stall while the sort moves s larger entries up one
//   slot each, then writes the word into the hole; s is at most the fill.
// Batch end: each rectangle is read (S_SUP_RDI, S_SUP_LDI) and compared with later ones
//   (S_SUP_RDJ to S_SUP_CMP, overlap pipeline), then streamed out via S_EM_RD, S_EM_CK.
// Reset (rst_n, synchronous): clears count, overflow flag, threshold to 128 and FSM;
//   the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// overlap_rect_suppression: area-ordered overlap suppression of rectangles
// Keeps the batch sorted by area on arrival, then marks and streams survivors.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_rect_suppression #(
  parameter int MAX_RECTS = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  ors_pkg::in_word_t                     in_word,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output ors_pkg::out_word_t                    out_word,
  input  wire                                   cfg_wr_en,
  input  wire [ors_pkg::ORS_THR_BITS-1:0]       cfg_wr_data
);
  import ors_pkg::*;

  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int NW = ORS_AREA_BITS + ORS_THR_BITS;   // need = area * threshold
  localparam int PW = 2 * ORS_COORD_BITS + 2;         // intersection product
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECTS);

  // control state
  ors_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;   // words stored in this batch
  logic [CW-1:0] k_r, k_nxt;           // insertion hole
  logic [CW-1:0] i_r, i_nxt;           // rectangle under test / emit index
  logic [CW-1:0] j_r, j_nxt;           // later rectangle being compared
  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] emitted_r, emitted_nxt;
  logic          overflow_r, overflow_nxt;
  logic          end_r, end_nxt;
  logic [ORS_THR_BITS-1:0] thr_r;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  rect_t         new_rect_r, new_rect_nxt;
  logic [ORS_AREA_BITS-1:0] new_area_r;
  rect_t         ri_r;
  logic [NW-1:0] need_r;
  out_word_t     out_r, out_nxt;

  // rectangle memory port
  logic    wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr;
  entry_t  wr_data, rd_data;

  // keep marks: 1-bit memory, written during suppression, read while emitting
  logic keep_mem [MAX_RECTS];
  logic keep_wr_en, keep_wr_val, keep_rd_en, keep_rd_r;

  logic [PW-1:0] inter_area;
  logic          covered;

  ors_rect_mem #(
    .DEPTH(MAX_RECTS),
    .AW   (IW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // rect i held in ri_r, rect j straight off the memory read register
  ors_overlap u_ovl (
    .clk       (clk),
    .rect_a    (ri_r),
    .rect_b    (rd_data.rect),
    .inter_area(inter_area)
  );

  // 256*inter >= area*threshold, exact
  assign covered = ({2'b00, inter_area, 8'h00} >= {{(PW + 10 - NW){1'b0}}, need_r});

  always_ff @(posedge clk) begin
    if (keep_wr_en) begin
      keep_mem[i_r[IW-1:0]] <= keep_wr_val;
    end
    if (keep_rd_en) begin
      keep_rd_r <= keep_mem[i_r[IW-1:0]];
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ORS_THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      kept_r      <= '0;
      emitted_r   <= '0;
      end_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kept_r      <= kept_nxt;
      emitted_r   <= emitted_nxt;
      end_r       <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_rect_r <= new_rect_nxt;
    out_r      <= out_nxt;
    if (state_r == S_AREA) begin
      new_area_r <= new_rect_r.w * new_rect_r.h;
    end
    if (state_r == S_SUP_LDI) begin
      ri_r   <= rd_data.rect;
      need_r <= rd_data.area * thr_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    kept_nxt      = kept_r;
    emitted_nxt   = emitted_r;
    end_nxt       = end_r;
    new_rect_nxt  = new_rect_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = k_r[IW-1:0];
    wr_data       = '{rect: new_rect_r, area: new_area_r};
    rd_en         = 1'b0;
    rd_addr       = i_r[IW-1:0];
    keep_wr_en    = 1'b0;
    keep_wr_val   = 1'b0;
    keep_rd_en    = 1'b0;
    in_stall      = (state_r != S_IDLE);

    // output word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          new_rect_nxt = '{l: in_word.left, t: in_word.top,
                           w: in_word.width, h: in_word.height};
          end_nxt      = in_word.batch_end;
          if (count_r < MAX_CNT) begin
            state_nxt = S_AREA;
          end else begin
            // store full: drop the word, flag it
            overflow_nxt = 1'b1;
            if (in_word.batch_end) begin
              i_nxt     = '0;
              kept_nxt  = '0;
              state_nxt = S_SUP_RDI;
            end
          end
        end
      end
      S_AREA: begin
        k_nxt     = count_r;
        state_nxt = S_INS_RD;
      end
      S_INS_RD: begin
        if (k_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          i_nxt     = '0;
          kept_nxt  = '0;
          state_nxt = end_r ? S_SUP_RDI : S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IW'(k_r - 1'b1);
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data.area > new_area_r) begin
          // larger neighbor moves up one slot; equal areas stay ahead
          wr_data   = rd_data;
          k_nxt     = k_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + 1'b1;
          i_nxt     = '0;
          kept_nxt  = '0;
          state_nxt = end_r ? S_SUP_RDI : S_IDLE;
        end
      end
      S_SUP_RDI: begin
        if (i_r == count_r) begin
          i_nxt       = '0;
          emitted_nxt = '0;
          state_nxt   = S_EM_RD;
        end else begin
          rd_en     = 1'b1;
          j_nxt     = i_r + 1'b1;
          state_nxt = S_SUP_LDI;
        end
      end
      S_SUP_LDI: begin
        state_nxt = S_SUP_RDJ;
      end
      S_SUP_RDJ: begin
        if (j_r == count_r) begin
          keep_wr_en  = 1'b1;
          keep_wr_val = 1'b1;
          kept_nxt    = kept_r + 1'b1;
          i_nxt       = i_r + 1'b1;
          state_nxt   = S_SUP_RDI;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = j_r[IW-1:0];
          state_nxt = S_SUP_D0;
        end
      end
      S_SUP_D0: state_nxt = S_SUP_D1;
      S_SUP_D1: state_nxt = S_SUP_CMP;
      S_SUP_CMP: begin
        if (covered) begin
          keep_wr_en = 1'b1;
          i_nxt      = i_r + 1'b1;
          state_nxt  = S_SUP_RDI;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SUP_RDJ;
        end
      end
      S_EM_RD: begin
        if (i_r == count_r) begin
          count_nxt    = '0;
          overflow_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          keep_rd_en = 1'b1;
          state_nxt  = S_EM_CK;
        end
      end
      S_EM_CK: begin
        if (!keep_rd_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_EM_RD;
        end else if (!out_valid_r || !out_stall) begin
          out_nxt = '{out_left:     rd_data.rect.l,
                      out_top:      rd_data.rect.t,
                      out_width:    rd_data.rect.w,
                      out_height:   rd_data.rect.h,
                      kept_total:   ORS_KEPT_BITS'(kept_r),
                      overflowed:   overflow_r,
                      final_result: (emitted_r + 1'b1 == kept_r)};
          out_valid_nxt = 1'b1;
          emitted_nxt   = emitted_r + 1'b1;
          i_nxt         = i_r + 1'b1;
          state_nxt     = S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT) else $error("store count past capacity");
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= count_r || state_r == S_IDLE || state_r == S_AREA
    || state_r == S_INS_RD || state_r == S_INS_CMP)
    else $error("more kept than stored");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUP_CMP |-> j_r > i_r) else $error("compare against earlier entry");
  a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> $past(state_r) == S_EM_CK)
    else $error("output word loaded outside emit");
`endif

endmodule

`default_nettype wire

### tb/tb_overlap_rect_suppression.sv
// ----------------------------------------------------------------------------
// tb_overlap_rect_suppression: self-checking bench for overlap suppression
// Feeds batches of rectangles under random idles and stalls. A predictor
// orders each batch by area and suppresses covered rectangles, and every
// result word is checked against it. The threshold is swept between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_overlap_rect_suppression;
  timeunit 1ns;
  timeprecision 1ps;

  import ors_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 340;    // directed rows and the full batch add the rest
  localparam int STALL_LIMIT  = 20000;  // cycles with no word moving
  localparam int SETTLE       = 80;     // idle time after the last word before a threshold write or the end

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_wr_en;
  logic [ORS_THR_BITS-1:0] cfg_wr_data;

  overlap_rect_suppression #(.MAX_RECTS(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bench copy of the block state
  rect_t                   batch_rects[$];
  bit                      batch_overflow;
  logic [ORS_THR_BITS-1:0] threshold;
  out_word_t               kept_words[$];   // survivors not yet seen at the output

  int errors, words_checked, batches, overflow_batches, items_sent;
  int in_idle_pct, out_idle_pct;
  int quiet_cycles;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  function automatic longint area_of(input rect_t r);
    return longint'(r.w) * longint'(r.h);
  endfunction

  function automatic longint shared_area(input rect_t a, input rect_t b);
    int x1, y1, x2, y2;
    x1 = (a.l > b.l) ? int'(a.l) : int'(b.l);
    y1 = (a.t > b.t) ? int'(a.t) : int'(b.t);
    x2 = (int'(a.l) + int'(a.w) < int'(b.l) + int'(b.w)) ?
         int'(a.l) + int'(a.w) : int'(b.l) + int'(b.w);
    y2 = (int'(a.t) + int'(a.h) < int'(b.t) + int'(b.h)) ?
         int'(a.t) + int'(a.h) : int'(b.t) + int'(b.h);
    if (x2 <= x1 || y2 <= y1) return 0;
    return longint'(x2 - x1) * longint'(y2 - y1);
  endfunction

  // Store one rectangle; at batch end sort stably by area, mark survivors
  // and queue their words. Returns how many words the batch produces.
  function automatic int suppress_step(input in_word_t w);
    rect_t r, cur;
    rect_t sorted[$];
    bit    keep[$];
    int    k, kept, sent;
    longint need;
    out_word_t o;
    r.l = w.left; r.t = w.top; r.w = w.width; r.h = w.height;
    if (batch_rects.size() < CAPACITY) batch_rects = {batch_rects, r};
    else batch_overflow = 1'b1;
    if (!w.batch_end) return 0;

    sorted = batch_rects;
    for (int i = 1; i < sorted.size(); i++) begin
      cur = sorted[i];
      k = i;
      while (k > 0 && area_of(sorted[k-1]) > area_of(cur)) begin
        sorted[k] = sorted[k-1];
        k--;
      end
      sorted[k] = cur;
    end

    kept = 0;
    for (int i = 0; i < sorted.size(); i++) begin
      need = area_of(sorted[i]) * longint'(threshold);
      keep = {keep, 1'b1};
      for (int j = i + 1; j < sorted.size(); j++)
        if ((shared_area(sorted[i], sorted[j]) << 8) >= need) begin
          keep[i] = 1'b0;
          break;
        end
      if (keep[i]) kept++;
    end

    sent = 0;
    for (int i = 0; i < sorted.size(); i++) begin
      if (!keep[i]) continue;
      o.out_left     = sorted[i].l;
      o.out_top      = sorted[i].t;
      o.out_width    = sorted[i].w;
      o.out_height   = sorted[i].h;
      o.kept_total   = kept[ORS_KEPT_BITS-1:0];
      o.overflowed   = batch_overflow;
      o.final_result = (sent + 1 == kept);
      kept_words = {kept_words, o};
      sent++;
    end
    batches++;
    if (batch_overflow) overflow_batches++;
    batch_rects.delete();
    batch_overflow = 1'b0;
    return sent;
  endfunction

  // Present one word and hold it until accepted; called at a rising edge.
  task automatic send_rect(input in_word_t w, output int n_words);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    items_sent++;
    n_words = suppress_step(w);
  endtask

  // Threshold writes only once the block has drained and settled.
  task automatic write_threshold(input logic [ORS_THR_BITS-1:0] v);
    in_valid <= 1'b0;
    wait (kept_words.size() == 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = v;
  endtask

  function automatic in_word_t make_rect(input int bx, input int by, input in_word_t prev,
                                         input bit last);
    in_word_t w;
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      w.left   = coord_t'($urandom);
      w.top    = coord_t'($urandom);
      w.width  = coord_t'($urandom);
      w.height = coord_t'($urandom);
    end else if (pick == 1) begin
      w = prev;                    // duplicate: equal area, full cover
    end else begin
      w.left   = coord_t'(bx + int'($urandom_range(48)));
      w.top    = coord_t'(by + int'($urandom_range(48)));
      w.width  = coord_t'($urandom_range(64));
      w.height = coord_t'($urandom_range(64));
    end
    w.batch_end = last;
    return w;
  endfunction

  task automatic send_batch(input int count);
    in_word_t w;
    int bx, by, n;
    bx = $urandom_range(3900);
    by = $urandom_range(3900);
    w = '0;
    for (int i = 0; i < count; i++) begin
      w = make_rect(bx, by, w, i == count - 1);
      send_rect(w, n);
    end
  endtask

  // Directed rows; has_exp rows carry a single result typed in here.
  typedef struct {
    in_word_t  word;
    bit        has_exp;
    out_word_t exp;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // lone rectangle at both extremes comes straight back
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 6'd1, 1'b0, 1'b1}},
    '{'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1}, 1'b1,
      '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 6'd1, 1'b0, 1'b1}},
    // identical pair: the earlier one is fully covered
    '{'{12'd10, 12'd10, 12'd20, 12'd20, 1'b0}, 1'b0, '0},
    '{'{12'd10, 12'd10, 12'd20, 12'd20, 1'b1}, 1'b0, '0},
    // disjoint pair: both survive
    '{'{12'd0, 12'd0, 12'd8, 12'd8, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd100, 12'd8, 12'd8, 1'b1}, 1'b0, '0},
    // zero-area box dropped against a later box far away
    '{'{12'd500, 12'd500, 12'd0, 12'd30, 1'b0}, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd5, 12'd5, 1'b1}, 1'b0, '0},
    // arrival order is large, small, equal-small: sort must be stable
    '{'{12'd40, 12'd40, 12'd30, 12'd30, 1'b0}, 1'b0, '0},
    '{'{12'd45, 12'd45, 12'd4, 12'd6, 1'b0}, 1'b0, '0},
    '{'{12'd200, 12'd200, 12'd6, 12'd4, 1'b1}, 1'b0, '0},
    // half overlap right at the reset threshold
    '{'{12'd0, 12'd0, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
    '{'{12'd5, 12'd0, 12'd10, 12'd12, 1'b1}, 1'b0, '0},
    // just under half
    '{'{12'd0, 12'd0, 12'd10, 12'd10, 1'b0}, 1'b0, '0},
    '{'{12'd6, 12'd0, 12'd10, 12'd12, 1'b1}, 1'b0, '0},
    // corners far out: sums pass the coordinate range
    '{'{12'hFF0, 12'hFF0, 12'hFFF, 12'hFFF, 1'b0}, 1'b0, '0},
    '{'{12'hFF8, 12'hFF8, 12'hFFF, 12'h800, 1'b1}, 1'b0, '0}
  };

  // Result side: random stall, check against the oldest survivor.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (kept_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %p", out_word));
        end else begin
          e = kept_words.pop_front();
          if (out_word.out_left !== e.out_left)
            report_mismatch($sformatf("out_left %0d exp %0d", out_word.out_left, e.out_left));
          if (out_word.out_top !== e.out_top)
            report_mismatch($sformatf("out_top %0d exp %0d", out_word.out_top, e.out_top));
          if (out_word.out_width !== e.out_width)
            report_mismatch($sformatf("out_width %0d exp %0d",
                                      out_word.out_width, e.out_width));
          if (out_word.out_height !== e.out_height)
            report_mismatch($sformatf("out_height %0d exp %0d",
                                      out_word.out_height, e.out_height));
          if (out_word.kept_total !== e.kept_total)
            report_mismatch($sformatf("kept_total %0d exp %0d",
                                      out_word.kept_total, e.kept_total));
          if (out_word.overflowed !== e.overflowed)
            report_mismatch($sformatf("overflowed %0b exp %0b",
                                      out_word.overflowed, e.overflowed));
          if (out_word.final_result !== e.final_result)
            report_mismatch($sformatf("final_result %0b exp %0b",
                                      out_word.final_result, e.final_result));
        end
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Watchdog: only cycles in which no word moves on either side count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
      $display("tb_overlap_rect_suppression: done, errors");
      $finish;
    end
  end

  // Threshold sweep: 0, 256, all-ones register, their neighbours, reset value, then random settings.
  initial begin
    int n;
    int phase_start;
    logic [ORS_THR_BITS-1:0] sweep[$];
    errors = 0; words_checked = 0; batches = 0; overflow_batches = 0;
    items_sent = 0; quiet_cycles = 0;
    in_idle_pct = IDLE_PCT; out_idle_pct = IDLE_PCT;
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    batch_overflow = 1'b0;
    threshold = ORS_THR_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_rect(dir_rows[i].word, n);
      if (dir_rows[i].has_exp) begin
        kept_words[kept_words.size() - 1] = dir_rows[i].exp;
      end
    end
    send_batch(CAPACITY + 3);      // store full: extra boxes dropped, flag set

    sweep = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd255, 9'd257, 9'd128};
    repeat (3) sweep = {sweep, ORS_THR_BITS'($urandom_range(511))};
    foreach (sweep[p]) begin
      write_threshold(sweep[p]);
      // one phase runs without any idling on either side
      in_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
      out_idle_pct = (p == 2) ? 0 : IDLE_PCT;
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / sweep.size()) begin
        n = $urandom_range(99);
        if (n < 80)      send_batch($urandom_range(1, 8));
        else if (n < 95) send_batch($urandom_range(9, CAPACITY - 1));
        else             send_batch($urandom_range(CAPACITY, CAPACITY + 8));
      end
    end

    in_valid <= 1'b0;
    wait (kept_words.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d rectangles in %0d batches (%0d over capacity), %0d words checked",
             items_sent, batches, overflow_batches, words_checked);
    $display("thresholds swept from 0 through 511, random idles and output stalls");
    if (errors == 0) $display("tb_overlap_rect_suppression: done, clean");
    else $display("tb_overlap_rect_suppression: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
